FILE: rtl/mrsb_pkg.sv
// Package for the single-base strong probable prime tester.
// Holds operand width constants shared by the interfaces and the top level.
// No dependencies.
package mrsb_pkg;
    localparam int OPERAND_BITS = 32;
    localparam int CNT_BITS = $clog2(OPERAND_BITS + 1);
    typedef logic [OPERAND_BITS-1:0] operand_t;
endpackage

FILE: rtl/mrsb_ifc.sv
// Valid/ready channel interfaces for the tester.
// Depends on mrsb_pkg.
interface mrsb_in_if;
    logic  valid;
    logic  ready;
    mrsb_pkg::operand_t candidate;
    mrsb_pkg::operand_t base;
    modport source (output valid, output candidate, output base, input ready);
    modport sink   (input valid, input candidate, input base, output ready);
endinterface

interface mrsb_out_if;
    logic valid;
    logic ready;
    logic probable_prime;
    modport source (output valid, output probable_prime, input ready);
    modport sink   (input valid, input probable_prime, output ready);
endinterface

FILE: rtl/miller_rabin_single_base.sv
// Strong probable prime test of one candidate n to one base a.
// Channel in carries candidate and base; channel out carries one verdict
// beat, probable_prime, per input beat. Depends on mrsb_pkg and mrsb_ifc.
//
// Usage: one item is worked on at a time. Input ready is high only while
// the block is idle. A beat is worked in phases: reduce a mod n by
// bit-serial restoring division, binary gcd, factor n-1, then
// square-and-multiply with a bit-serial modular multiplier, then up to W-2
// squarings of x. Products and squarings together number at most 2W-3;
// they all share the one shift-add modular multiplier. A candidate below
// three or even gets its verdict the cycle after it is accepted.
// The verdict is held in an output register until taken; the block does
// not accept a new item while a verdict waits. Reset clears the
// controller and drops any item in progress.
module miller_rabin_single_base (
    input  logic        clk,
    input  logic        rst_n,
    mrsb_in_if.sink     in_ch,
    mrsb_out_if.source  out_ch
);
    localparam int W = mrsb_pkg::OPERAND_BITS;
    localparam int CB = mrsb_pkg::CNT_BITS;

    localparam logic [3:0] S_IDLE = 4'd0, S_RED = 4'd1, S_GCD = 4'd2,
        S_FAC = 4'd3, S_EXP = 4'd4, S_MUL = 4'd5, S_CHK = 4'd6,
        S_SQ = 4'd7, S_DONE = 4'd8;
    localparam logic [1:0] M_ACC = 2'd0, M_BASE = 2'd1, M_SQ = 2'd2;

    logic [3:0]   state_reg;
    logic [W-1:0] n_reg, a_reg, q_reg, x_reg, b_reg;
    logic [W-1:0] gu_reg, gv_reg;
    logic [W-1:0] mx_reg, my_reg, mp_reg;
    logic [CB-1:0] cnt_reg, k_reg;
    logic [1:0]   mdst_reg;
    logic         res_reg, ovalid_reg;

    // Doubling step of the shift-add multiplier, kept below n.
    logic [W:0] dbl, dadd, dsum;
    logic [W-1:0] dstep;
    assign dbl   = {mp_reg, 1'b0};
    assign dstep = (dbl >= {1'b0, n_reg}) ? W'(dbl - {1'b0, n_reg}) : dbl[W-1:0];
    assign dadd  = {1'b0, dstep} + {1'b0, my_reg};
    assign dsum  = mx_reg[W-1] ? dadd : {1'b0, dstep};

    logic [W-1:0] msum;
    assign msum = (dsum >= {1'b0, n_reg}) ? W'(dsum - {1'b0, n_reg}) : dsum[W-1:0];

    // Restoring division step for a mod n: bring in one bit of a.
    logic [W:0] rsh;
    assign rsh = {mp_reg, mx_reg[W-1]};

    assign in_ch.ready           = (state_reg == S_IDLE);
    assign out_ch.valid          = ovalid_reg;
    assign out_ch.probable_prime = res_reg;

    logic [W-1:0] nm1;
    assign nm1 = n_reg - W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        n_reg  <= in_ch.candidate[W-1:0];
                        a_reg  <= in_ch.base[W-1:0];
                        mx_reg <= in_ch.base[W-1:0];
                        mp_reg <= '0;
                        cnt_reg <= '0;
                        if (in_ch.candidate[W-1:0] < W'(3) || !in_ch.candidate[0])
                        begin
                            res_reg    <= 1'b0;
                            ovalid_reg <= 1'b1;
                            state_reg  <= S_DONE;
                        end
                        else
                            state_reg <= S_RED;
                    end
                end
                S_RED:
                begin
                    mp_reg <= (rsh >= {1'b0, n_reg}) ? W'(rsh - {1'b0, n_reg}) : rsh[W-1:0];
                    mx_reg <= {mx_reg[W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + CB'(1);
                    if (cnt_reg == CB'(W - 1))
                    begin
                        gu_reg <= n_reg;
                        gv_reg <= (rsh >= {1'b0, n_reg}) ? W'(rsh - {1'b0, n_reg}) : rsh[W-1:0];
                        a_reg  <= (rsh >= {1'b0, n_reg}) ? W'(rsh - {1'b0, n_reg}) : rsh[W-1:0];
                        state_reg <= S_GCD;
                    end
                end
                S_GCD:
                begin
                    // n is odd, so gcd(n, a mod n) is odd: binary gcd with u odd.
                    if (gv_reg == '0)
                    begin
                        if (gu_reg != W'(1))
                        begin
                            res_reg    <= 1'b0;
                            ovalid_reg <= 1'b1;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            q_reg   <= nm1 >> 1;
                            k_reg   <= CB'(1);
                            state_reg <= S_FAC;
                        end
                    end
                    else if (!gv_reg[0])
                        gv_reg <= gv_reg >> 1;
                    else if (gv_reg >= gu_reg)
                        gv_reg <= (gv_reg - gu_reg) >> 1;
                    else
                    begin
                        gu_reg <= gv_reg;
                        gv_reg <= (gu_reg - gv_reg) >> 1;
                    end
                end
                S_FAC:
                begin
                    if (!q_reg[0])
                    begin
                        q_reg <= q_reg >> 1;
                        k_reg <= k_reg + CB'(1);
                    end
                    else
                    begin
                        x_reg <= W'(1);
                        b_reg <= a_reg;
                        state_reg <= S_EXP;
                    end
                end
                S_EXP:
                begin
                    cnt_reg <= '0;
                    mp_reg  <= '0;
                    if (q_reg == '0)
                        state_reg <= S_CHK;
                    else if (q_reg[0])
                    begin
                        mx_reg <= x_reg; my_reg <= b_reg; mdst_reg <= M_ACC;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        mx_reg <= b_reg; my_reg <= b_reg; mdst_reg <= M_BASE;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    mp_reg  <= msum;
                    mx_reg  <= {mx_reg[W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + CB'(1);
                    if (cnt_reg == CB'(W - 1))
                    begin
                        case (mdst_reg)
                            M_ACC:
                            begin
                                x_reg <= msum;
                                q_reg[0] <= 1'b0;
                                state_reg <= S_EXP;
                            end
                            M_BASE:
                            begin
                                b_reg <= msum;
                                q_reg <= q_reg >> 1;
                                state_reg <= S_EXP;
                            end
                            default:
                            begin
                                x_reg <= msum;
                                k_reg <= k_reg - CB'(1);
                                state_reg <= S_SQ;
                            end
                        endcase
                    end
                end
                S_CHK:
                begin
                    if (x_reg == W'(1))
                    begin
                        res_reg <= 1'b1; ovalid_reg <= 1'b1; state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    cnt_reg <= '0;
                    mp_reg  <= '0;
                    if (x_reg == nm1)
                    begin
                        res_reg <= 1'b1; ovalid_reg <= 1'b1; state_reg <= S_DONE;
                    end
                    else if (k_reg <= CB'(1))
                    begin
                        res_reg <= 1'b0; ovalid_reg <= 1'b1; state_reg <= S_DONE;
                    end
                    else
                    begin
                        mx_reg <= x_reg; my_reg <= x_reg; mdst_reg <= M_SQ;
                        state_reg <= S_MUL;
                    end
                end
                S_DONE:
                begin
                    if (out_ch.ready)
                    begin
                        ovalid_reg <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    ap_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> state_reg == S_DONE) else $error("verdict outside done");
    ap_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> !in_ch.ready) else $error("accept while verdict waits");
    ap_mul_below: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |-> mp_reg < n_reg) else $error("partial product not reduced");
    ap_gcd_odd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_GCD |-> gu_reg[0]) else $error("gcd operand even");
endmodule

FILE: test/mrsb_checker.sv
// Checker for the single-base strong probable prime tester.
// Watches both channels, predicts each verdict and compares it.
// Depends on mrsb_pkg and mrsb_ifc.
module mrsb_checker (
    input  logic clk,
    input  logic rst_n,
    mrsb_in_if   in_ch,
    mrsb_out_if  out_ch,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    bit verdict_q[$];

    function automatic longint unsigned mulmod(longint unsigned x, longint unsigned y,
                                               longint unsigned m);
        return (x * y) % m;
    endfunction

    function automatic bit sprp(mrsb_pkg::operand_t cand, mrsb_pkg::operand_t wit);
        longint unsigned n, a, u, v, r, q, x, acc, b, e;
        int k;
        n = cand;
        a = wit;
        if (n < 3 || n[0] == 1'b0)
            return 1'b0;
        u = n;
        v = a;
        while (v != 0)
        begin
            r = u % v;
            u = v;
            v = r;
        end
        if (u > 1)
            return 1'b0;
        q = n - 1;
        k = 0;
        while (q[0] == 1'b0)
        begin
            q = q >> 1;
            k++;
        end
        acc = 1;
        b = a % n;
        e = q;
        while (e != 0)
        begin
            if (e[0])
                acc = mulmod(acc, b, n);
            b = mulmod(b, b, n);
            e = e >> 1;
        end
        x = acc;
        if (x == 1)
            return 1'b1;
        for (int i = 0; i < k; i++)
        begin
            if (x == n - 1)
                return 1'b1;
            x = mulmod(x, x, n);
        end
        return 1'b0;
    endfunction

    assign pending = verdict_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            verdict_q.delete();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                verdict_q.push_back(sprp(in_ch.candidate, in_ch.base));
            if (out_ch.valid && out_ch.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("probable_prime: verdict beat with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    bit exp_v;
                    exp_v = verdict_q.pop_front();
                    if (exp_v !== out_ch.probable_prime)
                    begin
                        $error("probable_prime: expected %0d, actual %0d",
                               exp_v, out_ch.probable_prime);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: test/miller_rabin_single_base_tb.sv
// Testbench top for the single-base strong probable prime tester.
// Drives candidate/base beats, stalls the verdict side, reports the verdict.
// Depends on mrsb_pkg, mrsb_ifc, mrsb_checker and the block.
module miller_rabin_single_base_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 120;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    bit   calm;
    bit   hold_off;
    int   sent;

    mrsb_in_if  in_ch ();
    mrsb_out_if out_ch ();

    miller_rabin_single_base DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    mrsb_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #6 clk = ~clk;

    initial
    begin
        #100ms;
        $display("Verification failed");
        $finish;
    end

    // The verdict side stalls at random, or for a long stretch when asked.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ch.ready <= 1'b0;
                repeat (9000) @(negedge clk);
                hold_off = 1'b0;
            end
            else
                out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
        end
    end

    // Valid is already low on entry; each drive lands on a fresh falling edge.
    task automatic send_beat(mrsb_pkg::operand_t cand, mrsb_pkg::operand_t wit);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 14)
            @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.candidate <= cand;
        in_ch.base <= wit;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
        in_ch.valid <= 1'b0;
    endtask

    function automatic mrsb_pkg::operand_t rand_word();
        return {$urandom()};
    endfunction

    initial
    begin
        mrsb_pkg::operand_t cand;
        mrsb_pkg::operand_t wit;
        int cycles;
        in_ch.valid = 1'b0;
        in_ch.candidate = '0;
        in_ch.base = '0;
        calm = 1'b0;
        hold_off = 1'b0;
        sent = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: small candidates, zero and unit bases, extremes, known primes.
        send_beat(32'd0, 32'd5);
        send_beat(32'd1, 32'd1);
        send_beat(32'd2, 32'd1);
        send_beat(32'd3, 32'd2);
        send_beat(32'd7, 32'd0);
        send_beat(32'd7, 32'd14);
        send_beat(32'd9, 32'd1);
        send_beat(32'd2047, 32'd2);
        send_beat(32'd341, 32'd2);
        send_beat(32'd561, 32'd2);
        send_beat(32'd4294967291, 32'd2);
        send_beat(32'd4294967291, 32'hFFFF_FFFF);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(32'hFFFF_FFFF, 32'd2);
        send_beat(32'hFFFF_FFFE, 32'd3);
        send_beat(32'h8000_0001, 32'h7FFF_FFFF);
        send_beat(32'd2147483647, 32'h5555_5555);
        send_beat(32'd3215031751, 32'd2);
        send_beat(32'd65537, 32'hAAAA_AAAA);
        send_beat(32'd97, 32'd96);

        // Long stall on the verdict side while beats keep coming.
        hold_off = 1'b1;
        send_beat(32'd101, 32'd3);
        send_beat(32'd103, 32'd5);
        send_beat(32'd1009, 32'd7);

        // Pause until every verdict is back.
        cycles = 0;
        while (pending != 0 && cycles < 100000)
        begin
            @(negedge clk);
            cycles++;
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 40 && i < 70);
            cand = rand_word();
            case ($urandom_range(9))
                0: cand = $urandom_range(20);
                1: cand[31:16] = '0;
                default: cand[0] = 1'b1;
            endcase
            case ($urandom_range(9))
                0: wit = $urandom_range(3);
                1: wit = cand;
                2: wit = cand - 1;
                default: wit = rand_word();
            endcase
            send_beat(cand, wit);
        end
        calm = 1'b0;

        cycles = 0;
        while (pending != 0 && cycles < 1000000)
        begin
            @(negedge clk);
            cycles++;
        end
        repeat (4000) @(negedge clk);

        $display("Sent %0d candidate/base beats: directed corner cases, stalls, random operands.",
                 sent);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
